// ----- sv/sati_pkg.sv -----
// Shared types and constants for the sparse angle table interpolator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package sati_pkg;

  localparam int NCOMP     = 9;   // lift, drag and torque, three axes each
  localparam int VAL_W     = 32;  // Q16.16 record value
  localparam int ANGLE_W   = 16;  // Q8.8 angle
  localparam int FRAC      = 8;   // fraction bits of the angle
  localparam int WGT_W     = 16;  // Q0.16 weight
  localparam int CIDX_W    = 4;   // component index

  typedef logic [NCOMP-1:0][VAL_W-1:0] row_t;

  typedef enum logic [1:0] {
    OP_STORE = 2'd0,
    OP_CLEAR = 2'd1,
    OP_QUERY = 2'd2,
    OP_RSVD  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NODATA = 2'd1,
    ST_RANGE  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DIV_GO,
    S_DIV,
    S_RD_LO,
    S_RD_HI,
    S_MUL,
    S_DRAIN,
    S_EX_RD,
    S_EX_CAP,
    S_DONE
  } state_t;

  // Tag that travels with a component through the interpolation pipeline.
  typedef struct packed {
    logic              vld;
    logic [CIDX_W-1:0] idx;
  } lane_tag_t;

endpackage

`default_nettype wire

// ----- sv/sparse_angle_table_interpolator.sv -----
// Sparse angle table interpolator: stores nine-value records at whole-degree
// keys and answers queries exactly or by linear interpolation.
// Input channel (in_valid/in_ready) carries an opcode, a Q8.8 angle and a
// record; result channel (out_valid/out_ready) returns one status and nine
// values per item. Store, clear and reserved items go straight to the done
// state. A query that hits a filled slot exactly reads that row and returns it.
// Any other query scans the slot-filled map 16 slots per cycle for the
// nearest filled keys below and above; with both found it runs the bit-serial
// weight divider, reads the two neighbor rows from the record memory over its
// one read port and pushes nine components through a shared two-stage multiplier.
// One item is worked on at a time; in_ready is high while the engine is
// idle, also while a finished result still waits in the output register.
// When the receiver stalls, a finished item waits until the output register
// frees up. Reset empties the table at once (filled bits are flip-flops);
// the record memory itself is not cleared and is only read at filled slots.
`default_nettype none

module sparse_angle_table_interpolator #(
  parameter int TABLE_SLOTS = 256
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_opcode,
  input  wire logic signed [15:0] in_angle,
  input  wire logic signed [31:0] in_lift_x,
  input  wire logic signed [31:0] in_lift_y,
  input  wire logic signed [31:0] in_lift_z,
  input  wire logic signed [31:0] in_drag_x,
  input  wire logic signed [31:0] in_drag_y,
  input  wire logic signed [31:0] in_drag_z,
  input  wire logic signed [31:0] in_torque_x,
  input  wire logic signed [31:0] in_torque_y,
  input  wire logic signed [31:0] in_torque_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_status,
  output logic signed [31:0]      out_lift_x,
  output logic signed [31:0]      out_lift_y,
  output logic signed [31:0]      out_lift_z,
  output logic signed [31:0]      out_drag_x,
  output logic signed [31:0]      out_drag_y,
  output logic signed [31:0]      out_drag_z,
  output logic signed [31:0]      out_torque_x,
  output logic signed [31:0]      out_torque_y,
  output logic signed [31:0]      out_torque_z
);
  import sati_pkg::*;

  localparam int SW     = (TABLE_SLOTS > 2) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CHUNK  = (TABLE_SLOTS < 16) ? TABLE_SLOTS : 16;
  localparam int NCHUNK = (TABLE_SLOTS + CHUNK - 1) / CHUNK;
  localparam int CKW    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int CW     = (SW + 2 > 18) ? SW + 2 : 18;
  localparam int NW     = CW + FRAC;
  localparam int DVW    = SW + FRAC;
  localparam logic signed [CW-1:0] HALF_S  = CW'(TABLE_SLOTS / 2);
  localparam logic signed [CW-1:0] SLOTS_S = CW'(TABLE_SLOTS);
  localparam logic signed [CW-1:0] RHALF_S = CW'(1 << (FRAC - 1));

  state_t state_r, state_nxt;

  logic [TABLE_SLOTS-1:0]        filled_r;
  logic [NCHUNK*CHUNK-1:0]       filled_pad;
  logic [CHUNK-1:0]              chunk_bits;

  logic signed [CW-1:0]          a_ext, fl, deg, st_slot_s, ex_slot_s;
  logic                          frac_nz, st_in_range, ex_hit;
  opcode_t                       op_in;

  logic signed [CW-1:0]          lo_lim_r, hi_lim_r;
  logic signed [ANGLE_W-1:0]     a_r;
  logic [SW-1:0]                 ex_slot_r, lo_r, hi_r, lo_sel, hi_sel;
  logic                          lo_found_r, hi_found_r, lo_hit, hi_hit;
  logic [CKW-1:0]                ck_r;
  logic                          last_chunk;

  row_t                          wrow, rd_row, lo_row_r, res_r, out_row_r;
  status_t                       status_r, out_status_r;
  logic                          out_valid_r;
  logic                          mem_we, mem_re;
  logic [SW-1:0]                 mem_raddr;

  logic                          div_start, div_done;
  logic [WGT_W-1:0]              wgt;
  logic signed [NW-1:0]          num_s, key_lo;

  logic [CIDX_W-1:0]             k_r;
  lane_tag_t                     lerp_tag_in, lerp_tag_out;
  logic [VAL_W-1:0]              lerp_val;
  logic                          accept, out_free;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign op_in    = opcode_t'(in_opcode);

  // ---- Angle decode at accept time -----------------------------------
  always_comb begin
    a_ext   = CW'(in_angle);
    fl      = a_ext >>> FRAC;
    frac_nz = (in_angle[FRAC-1:0] != '0);
    if (a_ext >= 0) begin
      deg = (a_ext + RHALF_S) >>> FRAC;
    end else begin
      deg = -((-a_ext + RHALF_S) >>> FRAC);
    end
    st_slot_s   = deg + HALF_S;
    st_in_range = (st_slot_s >= 0) && (st_slot_s < SLOTS_S);
    ex_slot_s   = fl + HALF_S;
    ex_hit      = !frac_nz && (ex_slot_s >= 0) && (ex_slot_s < SLOTS_S) &&
                  filled_r[ex_slot_s[SW-1:0]];
  end

  always_comb begin
    wrow[0] = in_lift_x;
    wrow[1] = in_lift_y;
    wrow[2] = in_lift_z;
    wrow[3] = in_drag_x;
    wrow[4] = in_drag_y;
    wrow[5] = in_drag_z;
    wrow[6] = in_torque_x;
    wrow[7] = in_torque_y;
    wrow[8] = in_torque_z;
  end

  // ---- Neighbor scan over one chunk of the filled map ----------------
  assign filled_pad = (NCHUNK*CHUNK)'(filled_r);
  assign chunk_bits = filled_pad[ck_r*CHUNK +: CHUNK];
  assign last_chunk = (ck_r == CKW'(NCHUNK - 1));

  always_comb begin
    int s_idx;
    logic signed [CW-1:0] s_val;
    lo_hit = 1'b0;
    hi_hit = 1'b0;
    lo_sel = '0;
    hi_sel = '0;
    for (int j = 0; j < CHUNK; j++) begin
      s_idx = int'(ck_r) * CHUNK + j;
      s_val = CW'(s_idx);
      // Keys below the angle: the last one wins. Keys above: the first.
      if (chunk_bits[j] && (s_val < lo_lim_r)) begin
        lo_hit = 1'b1;
        lo_sel = SW'(s_idx);
      end
      if (chunk_bits[j] && (s_val > hi_lim_r) && !hi_hit) begin
        hi_hit = 1'b1;
        hi_sel = SW'(s_idx);
      end
    end
  end

  // ---- Weight divider operands ----------------------------------------
  assign key_lo = (NW'($signed({1'b0, lo_r})) - NW'(HALF_S)) <<< FRAC;
  assign num_s  = NW'(a_r) - key_lo;

  sati_div #(.DVW(DVW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_s[DVW-1:0]),
    .den   ({SW'(hi_r - lo_r), FRAC'(0)}),
    .done  (div_done),
    .quot  (wgt)
  );

  sati_mem #(.DEPTH(TABLE_SLOTS), .AW(SW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (st_slot_s[SW-1:0]),
    .wdata (wrow),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd_row)
  );

  sati_lerp u_lerp (
    .clk     (clk),
    .rst_n   (rst_n),
    .tag_in  (lerp_tag_in),
    .lo      (lo_row_r[k_r]),
    .hi      (rd_row[k_r]),
    .wgt     (wgt),
    .tag_out (lerp_tag_out),
    .value   (lerp_val)
  );

  // ---- Next state ---------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (op_in == OP_QUERY) begin
            state_nxt = ex_hit ? S_EX_RD : S_SCAN;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (last_chunk) begin
          state_nxt = ((lo_found_r || lo_hit) && (hi_found_r || hi_hit)) ?
                      S_DIV_GO : S_DONE;
        end
      end
      S_DIV_GO: state_nxt = S_DIV;
      S_DIV:    state_nxt = div_done ? S_RD_LO : S_DIV;
      S_RD_LO:  state_nxt = S_RD_HI;
      S_RD_HI:  state_nxt = S_MUL;
      S_MUL:    state_nxt = (k_r == CIDX_W'(NCOMP - 1)) ? S_DRAIN : S_MUL;
      S_DRAIN: begin
        if (lerp_tag_out.vld && (lerp_tag_out.idx == CIDX_W'(NCOMP - 1))) begin
          state_nxt = S_DONE;
        end
      end
      S_EX_RD:  state_nxt = S_EX_CAP;
      S_EX_CAP: state_nxt = S_DONE;
      S_DONE:   state_nxt = out_free ? S_IDLE : S_DONE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // ---- FSM outputs ---------------------------------------------------------
  always_comb begin
    in_ready        = 1'b0;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    mem_raddr       = lo_r;
    div_start       = 1'b0;
    lerp_tag_in.vld = 1'b0;
    lerp_tag_in.idx = k_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        mem_we   = in_valid && (op_in == OP_STORE) && st_in_range;
      end
      S_DIV_GO: div_start = 1'b1;
      S_RD_LO: begin
        mem_re    = 1'b1;
        mem_raddr = lo_r;
      end
      S_RD_HI: begin
        mem_re    = 1'b1;
        mem_raddr = hi_r;
      end
      S_MUL:   lerp_tag_in.vld = 1'b1;
      S_EX_RD: begin
        mem_re    = 1'b1;
        mem_raddr = ex_slot_r;
      end
      default: ;
    endcase
  end

  // ---- Control registers ---------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      filled_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept && (op_in == OP_CLEAR)) begin
        filled_r <= '0;
      end else if (accept && (op_in == OP_STORE) && st_in_range) begin
        filled_r[st_slot_s[SW-1:0]] <= 1'b1;
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---- Datapath registers -------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      a_r        <= in_angle;
      lo_lim_r   <= fl + HALF_S + CW'(frac_nz);
      hi_lim_r   <= fl + HALF_S;
      ex_slot_r  <= ex_slot_s[SW-1:0];
      lo_found_r <= 1'b0;
      hi_found_r <= 1'b0;
      ck_r       <= '0;
      res_r      <= '0;
      status_r   <= (op_in == OP_STORE && !st_in_range) ? ST_RANGE : ST_OK;
    end
    if (state_r == S_SCAN) begin
      ck_r <= ck_r + 1'b1;
      if (lo_hit) begin
        lo_r       <= lo_sel;
        lo_found_r <= 1'b1;
      end
      if (hi_hit && !hi_found_r) begin
        hi_r       <= hi_sel;
        hi_found_r <= 1'b1;
      end
      if (last_chunk && !((lo_found_r || lo_hit) && (hi_found_r || hi_hit))) begin
        status_r <= ST_NODATA;
      end
    end
    if (state_r == S_RD_HI) begin
      lo_row_r <= rd_row;
      k_r      <= '0;
    end
    if (state_r == S_MUL) begin
      k_r <= k_r + 1'b1;
    end
    if (lerp_tag_out.vld) begin
      res_r[lerp_tag_out.idx] <= lerp_val;
    end
    if (state_r == S_EX_CAP) begin
      res_r <= rd_row;
    end
    if (state_r == S_DONE && out_free) begin
      out_row_r    <= res_r;
      out_status_r <= status_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_lift_x   = out_row_r[0];
  assign out_lift_y   = out_row_r[1];
  assign out_lift_z   = out_row_r[2];
  assign out_drag_x   = out_row_r[3];
  assign out_drag_y   = out_row_r[4];
  assign out_drag_z   = out_row_r[5];
  assign out_torque_x = out_row_r[6];
  assign out_torque_y = out_row_r[7];
  assign out_torque_z = out_row_r[8];

  // ---- Assertions ----------------------------------------------------------
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("weight divider finished outside the divide state");

  a_lerp_out_window: assert property (@(posedge clk) disable iff (!rst_n)
    lerp_tag_out.vld |-> (state_r == S_MUL || state_r == S_DRAIN))
    else $error("interpolation result arrived outside the multiply window");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && op_in == OP_CLEAR) |=> (filled_r == '0))
    else $error("clear item left filled slots behind");

endmodule

`default_nettype wire

// ----- sv/sati_mem.sv -----
// Record store: one row of nine values per table slot, synchronous read.
// Depends on sati_pkg for the row type.
`default_nettype none

module sati_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire sati_pkg::row_t wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output sati_pkg::row_t     rdata
);
  import sati_pkg::*;

  row_t mem [DEPTH];
  row_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- sv/sati_div.sv -----
// Restoring divider for the Q0.16 interpolation weight, one bit per cycle.
// Numerator is always below the divisor, so the quotient fits in 16 bits.
`default_nettype none

module sati_div #(
  parameter int DVW = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [DVW-1:0]             num,
  input  wire logic [DVW-1:0]             den,
  output logic                            done,
  output logic [sati_pkg::WGT_W-1:0]      quot
);
  import sati_pkg::*;

  localparam int CNTW = $clog2(WGT_W + 1);

  logic [DVW-1:0]   rem_r, rem_nxt;
  logic [DVW-1:0]   den_r;
  logic [WGT_W-1:0] q_r, q_nxt;
  logic [CNTW-1:0]  cnt_r;
  logic             done_r;
  logic [DVW:0]     shifted;

  always_comb begin
    shifted = {rem_r, 1'b0};
    if (shifted >= {1'b0, den_r}) begin
      rem_nxt = DVW'(shifted - {1'b0, den_r});
      q_nxt   = {q_r[WGT_W-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[DVW-1:0];
      q_nxt   = {q_r[WGT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNTW'(WGT_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      den_r <= den;
      q_r   <= '0;
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

`default_nettype wire

// ----- sv/sati_lerp.sv -----
// Two-stage interpolation pipe: lo + round_half_up((hi - lo) * w / 2^16).
// One component enters per cycle; a tag carries its index to the output.
`default_nettype none

module sati_lerp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire sati_pkg::lane_tag_t           tag_in,
  input  wire logic [sati_pkg::VAL_W-1:0]    lo,
  input  wire logic [sati_pkg::VAL_W-1:0]    hi,
  input  wire logic [sati_pkg::WGT_W-1:0]    wgt,
  output sati_pkg::lane_tag_t                tag_out,
  output logic [sati_pkg::VAL_W-1:0]         value
);
  import sati_pkg::*;

  localparam int DW = VAL_W + 1;
  localparam int PW = DW + WGT_W + 1;

  lane_tag_t               tag1_r, tag2_r;
  logic signed [PW-1:0]    prod_r;
  logic [VAL_W-1:0]        lo1_r, val_r;
  logic signed [DW-1:0]    diff;
  logic signed [PW-1:0]    rnd;

  assign diff = $signed({hi[VAL_W-1], hi}) - $signed({lo[VAL_W-1], lo});
  assign rnd  = (prod_r + PW'(32'sd32768)) >>> WGT_W;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
    end else begin
      tag1_r <= tag_in;
      tag2_r <= tag1_r;
    end
  end

  // The result always lies between lo and hi, so the low bits are exact.
  always_ff @(posedge clk) begin
    prod_r <= PW'(diff) * PW'($signed({1'b0, wgt}));
    lo1_r  <= lo;
    val_r  <= lo1_r + rnd[VAL_W-1:0];
  end

  assign tag_out = tag2_r;
  assign value   = val_r;

endmodule

`default_nettype wire

// ----- tb/sv/sparse_angle_table_interpolator_tb.sv -----
// Testbench for the sparse angle table interpolator: directed table, then random store,
// query, clear and reserved traffic checked against an in-bench predictor. Needs sati_pkg.
`timescale 1ns / 1ps

module sparse_angle_table_interpolator_tb;
  import sati_pkg::*;

  localparam int SLOTS      = 256;
  localparam int HALF_SLOTS = SLOTS / 2;
  localparam int UNIT       = 1 << FRAC;
  localparam int N_RANDOM   = 1930;

  typedef struct {
    status_t                st;
    logic signed [VAL_W-1:0] v [NCOMP];
  } answer_t;

  typedef struct {
    opcode_t                   op;
    logic signed [ANGLE_W-1:0] ang;
    logic [VAL_W-1:0]          seed;
    bit                        known;
    status_t                   st;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_opcode = '0;
  logic signed [ANGLE_W-1:0] in_angle = '0;
  logic signed [VAL_W-1:0] in_rec [NCOMP];
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic signed [VAL_W-1:0] out_rec [NCOMP];

  bit                      table_filled [SLOTS];
  logic signed [VAL_W-1:0] table_rec [SLOTS][NCOMP];
  answer_t                 pending_answers [$];
  int                      errs = 0;
  int                      n_received = 0;
  dir_row_t                rows [16];

  initial begin
    for (int k = 0; k < NCOMP; k++) in_rec[k] = '0;
  end

  sparse_angle_table_interpolator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_opcode(in_opcode), .in_angle(in_angle),
    .in_lift_x(in_rec[0]), .in_lift_y(in_rec[1]), .in_lift_z(in_rec[2]),
    .in_drag_x(in_rec[3]), .in_drag_y(in_rec[4]), .in_drag_z(in_rec[5]),
    .in_torque_x(in_rec[6]), .in_torque_y(in_rec[7]), .in_torque_z(in_rec[8]),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_lift_x(out_rec[0]), .out_lift_y(out_rec[1]), .out_lift_z(out_rec[2]),
    .out_drag_x(out_rec[3]), .out_drag_y(out_rec[4]), .out_drag_z(out_rec[5]),
    .out_torque_x(out_rec[6]), .out_torque_y(out_rec[7]), .out_torque_z(out_rec[8])
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Computes the answer to one item and updates the table copy accordingly.
  function automatic answer_t predict_answer(opcode_t op, logic signed [ANGLE_W-1:0] ang,
                                             logic signed [VAL_W-1:0] vals [NCOMP]);
    answer_t r;
    longint a, deg, slot, p, q, w, diff, lo_v, key;
    int lo, hi;
    bit hit;
    r.st = ST_OK;
    for (int k = 0; k < NCOMP; k++) r.v[k] = '0;
    a = ang;
    case (op)
      OP_STORE: begin
        deg = (a >= 0) ? ((a + UNIT / 2) >>> FRAC) : -((-a + UNIT / 2) >>> FRAC);
        slot = deg + HALF_SLOTS;
        if (slot < 0 || slot >= SLOTS) begin
          r.st = ST_RANGE;
        end else begin
          for (int k = 0; k < NCOMP; k++) table_rec[slot][k] = vals[k];
          table_filled[slot] = 1'b1;
        end
      end
      OP_CLEAR: begin
        for (int s = 0; s < SLOTS; s++) table_filled[s] = 1'b0;
      end
      OP_QUERY: begin
        hit = 1'b0;
        if (a % UNIT == 0) begin
          slot = a / UNIT + HALF_SLOTS;
          if (slot >= 0 && slot < SLOTS && table_filled[slot]) begin
            for (int k = 0; k < NCOMP; k++) r.v[k] = table_rec[slot][k];
            hit = 1'b1;
          end
        end
        if (!hit) begin
          lo = -1;
          hi = -1;
          for (int s = 0; s < SLOTS; s++) begin
            if (table_filled[s]) begin
              key = longint'(s - HALF_SLOTS) * UNIT;
              if (key < a) lo = s;
              else if (key > a && hi < 0) hi = s;
            end
          end
          if (lo < 0 || hi < 0) begin
            r.st = ST_NODATA;
          end else begin
            p = longint'(lo - HALF_SLOTS) * UNIT;
            q = longint'(hi - HALF_SLOTS) * UNIT;
            w = ((a - p) * 65536) / (q - p);
            for (int k = 0; k < NCOMP; k++) begin
              lo_v = table_rec[lo][k];
              diff = longint'(table_rec[hi][k]) - lo_v;
              // Arithmetic shift floors, which gives rounding half up here.
              r.v[k] = VAL_W'(lo_v + ((diff * w + 32768) >>> 16));
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_item(opcode_t op, logic signed [ANGLE_W-1:0] ang,
                           logic signed [VAL_W-1:0] vals [NCOMP], bit known, status_t st);
    int gap;
    answer_t r;
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_angle <= ang;
    for (int k = 0; k < NCOMP; k++) in_rec[k] <= vals[k];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = predict_answer(op, ang, vals);
    if (known) begin
      r.st = st;
      for (int k = 0; k < NCOMP; k++) r.v[k] = '0;
    end
    pending_answers.push_back(r);
  endtask

  // Result side: random stalls, one long hold so the block backs up, and a run with none.
  initial begin
    int stall;
    answer_t e;
    string names [NCOMP];
    names = '{"lift_x", "lift_y", "lift_z", "drag_x", "drag_y", "drag_z",
              "torque_x", "torque_y", "torque_z"};
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = (n_received == 300) ? 200 : $urandom_range(0, 5);
      if (n_received > 600 && n_received < 700) stall = 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      n_received++;
      if (pending_answers.size() == 0) begin
        $error("result with no expectation waiting");
        errs++;
      end else begin
        e = pending_answers.pop_front();
        if (out_status !== e.st) begin
          $error("status: expected %0d, got %0d", e.st, out_status);
          errs++;
        end
        for (int k = 0; k < NCOMP; k++) begin
          if (out_rec[k] !== e.v[k]) begin
            $error("%s: expected %0d, got %0d", names[k], e.v[k], out_rec[k]);
            errs++;
          end
        end
      end
    end
  end

  initial begin
    logic signed [VAL_W-1:0] vals [NCOMP];
    logic signed [ANGLE_W-1:0] ang;
    opcode_t op;
    int pick, waited;
    rows[0]  = '{OP_QUERY, 16'sd0,      32'h0,        1'b1, ST_NODATA};
    rows[1]  = '{OP_STORE, 16'sh7fff,   32'h1234,     1'b1, ST_RANGE};
    rows[2]  = '{OP_STORE, 16'sd32640,  32'h1234,     1'b1, ST_RANGE};
    rows[3]  = '{OP_STORE, 16'sd32639,  32'h7fffffff, 1'b1, ST_OK};
    rows[4]  = '{OP_STORE, -16'sd32768, 32'h80000000, 1'b1, ST_OK};
    rows[5]  = '{OP_QUERY, -16'sd32768, 32'h0,        1'b0, ST_OK};
    rows[6]  = '{OP_QUERY, 16'sd0,      32'h0,        1'b0, ST_OK};
    rows[7]  = '{OP_STORE, 16'sd128,    32'h00010000, 1'b1, ST_OK};
    rows[8]  = '{OP_STORE, -16'sd128,   32'hffff0000, 1'b1, ST_OK};
    rows[9]  = '{OP_QUERY, 16'sd64,     32'h0,        1'b0, ST_OK};
    rows[10] = '{OP_QUERY, 16'sd32767,  32'h0,        1'b1, ST_NODATA};
    rows[11] = '{OP_RSVD,  16'sd256,    32'hffffffff, 1'b1, ST_OK};
    rows[12] = '{OP_CLEAR, 16'sd0,      32'h0,        1'b1, ST_OK};
    rows[13] = '{OP_QUERY, 16'sd256,    32'h0,        1'b1, ST_NODATA};
    rows[14] = '{OP_STORE, 16'sd256,    32'h7fffffff, 1'b1, ST_OK};
    rows[15] = '{OP_STORE, 16'sd1024,   32'h80000000, 1'b1, ST_OK};
    for (int s = 0; s < SLOTS; s++) table_filled[s] = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      for (int k = 0; k < NCOMP; k++) vals[k] = (k % 2) ? ~rows[i].seed : rows[i].seed;
      send_item(rows[i].op, rows[i].ang, vals, rows[i].known, rows[i].st);
    end
    for (int k = 0; k < NCOMP; k++) vals[k] = '0;
    send_item(OP_QUERY, 16'sd512, vals, 1'b0, ST_OK);
    send_item(OP_QUERY, 16'sd1000, vals, 1'b0, ST_OK);

    // Mostly stores and queries in a narrow window so neighbors exist.
    for (int i = 0; i < N_RANDOM; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) op = OP_CLEAR;
      else if (pick < 4) op = OP_RSVD;
      else if (pick < 42) op = OP_STORE;
      else op = OP_QUERY;
      if ($urandom_range(0, 6) == 0) ang = ANGLE_W'($urandom);
      else if ($urandom_range(0, 3) == 0) ang = ANGLE_W'(($urandom_range(0, 16) - 8) * UNIT);
      else ang = ANGLE_W'($urandom_range(0, 4095) - 2048);
      for (int k = 0; k < NCOMP; k++) begin
        case ($urandom_range(0, 15))
          0: vals[k] = 32'sh7fffffff;
          1: vals[k] = 32'sh80000000;
          default: vals[k] = $urandom;
        endcase
      end
      send_item(op, ang, vals, 1'b0, ST_OK);
    end
    in_valid <= 1'b0;

    waited = 0;
    while (pending_answers.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (100) @(posedge clk);
    if (errs == 0 && pending_answers.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/sati_pkg.sv
sv/sati_mem.sv
sv/sati_div.sv
sv/sati_lerp.sv
sv/sparse_angle_table_interpolator.sv
tb/sv/sparse_angle_table_interpolator_tb.sv
